// File: rtl/grwc_pkg.sv
// Shared types, constants and tables for the grid ray wall caster.
package grwc_pkg;

    // Defaults for the top-level parameters
    localparam int GRID_SIDE_DEF     = 14;
    localparam int MAX_STEPS_DEF     = 14;
    localparam int SCREEN_HEIGHT_DEF = 512;

    // Request kinds carried on the input side-band
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // Probe coordinates in Q.6 pixels; one cell is 2^CELL_SHIFT
    localparam int COORD_W    = 32;
    localparam int CELL_SHIFT = 12;
    localparam int CELL_Q     = 4096;
    localparam int STEP_LIM   = 4194304;
    localparam int LIM_W      = 23;

    // Trig unit
    localparam int ANG_W        = 16;
    localparam int TRIG_W       = 18;
    localparam int CORDIC_ITERS = 14;
    localparam int CORDIC_GAIN  = 9949;
    localparam int ITER_W       = 4;

    // Serial divider and square root
    localparam int DIVN_W = 40;
    localparam int DIVD_W = 48;
    localparam int D2_W   = 64;
    localparam int ROOT_W = 32;

    // Payload packing
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [TRIG_W-1:0]  t_trig;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    function automatic t_trig atan_val(input logic [ITER_W-1:0] idx);
        t_trig v;
        case (idx)
            4'd0:    v = 18'sd8192;
            4'd1:    v = 18'sd4836;
            4'd2:    v = 18'sd2555;
            4'd3:    v = 18'sd1297;
            4'd4:    v = 18'sd651;
            4'd5:    v = 18'sd326;
            4'd6:    v = 18'sd163;
            4'd7:    v = 18'sd81;
            4'd8:    v = 18'sd41;
            4'd9:    v = 18'sd20;
            4'd10:   v = 18'sd10;
            4'd11:   v = 18'sd5;
            4'd12:   v = 18'sd3;
            4'd13:   v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/grwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module grwc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 196
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/grwc_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine in Q1.14.
module grwc_cordic (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [grwc_pkg::ANG_W-1:0] i_angle,
    output grwc_pkg::t_trig            o_cos,
    output grwc_pkg::t_trig            o_sin,
    output grwc_pkg::t_unit_stat       o_stat
);

    logic                        r_busy;
    logic                        r_done;
    logic [grwc_pkg::ITER_W-1:0] r_i;
    grwc_pkg::t_trig             r_x;
    grwc_pkg::t_trig             r_y;
    grwc_pkg::t_trig             r_z;
    logic                        r_neg;

    grwc_pkg::t_trig w_a;
    grwc_pkg::t_trig w_xs;
    grwc_pkg::t_trig w_ys;
    grwc_pkg::t_trig w_at;

    assign w_a  = grwc_pkg::TRIG_W'($signed(i_angle));
    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_at = grwc_pkg::atan_val(r_i);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= grwc_pkg::TRIG_W'(grwc_pkg::CORDIC_GAIN);
                r_y    <= '0;
                // fold the angle into the right half plane
                if (w_a > 18'sd16384) begin
                    r_z   <= w_a - 18'sd32768;
                    r_neg <= 1'b1;
                end else if (w_a < -18'sd16384) begin
                    r_z   <= w_a + 18'sd32768;
                    r_neg <= 1'b1;
                end else begin
                    r_z   <= w_a;
                    r_neg <= 1'b0;
                end
            end else if (r_busy) begin
                if (!r_z[grwc_pkg::TRIG_W-1]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_at;
                end
                if (r_i == grwc_pkg::ITER_W'(grwc_pkg::CORDIC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_i <= r_i + 1'b1;
            end
        end
    end

    assign o_cos       = r_neg ? -r_x : r_x;
    assign o_sin       = r_neg ? -r_y : r_y;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// File: rtl/grwc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module grwc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [grwc_pkg::DIVN_W-1:0] i_dividend,
    input  logic [grwc_pkg::DIVD_W-1:0] i_divisor,
    output logic [grwc_pkg::DIVN_W-1:0] o_quot,
    output grwc_pkg::t_unit_stat        o_stat
);

    localparam int CNT_W = $clog2(grwc_pkg::DIVN_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [grwc_pkg::DIVD_W-1:0] r_rem;
    logic [grwc_pkg::DIVN_W-1:0] r_quot;
    logic [grwc_pkg::DIVD_W-1:0] r_dvs;

    logic [grwc_pkg::DIVD_W:0] w_t;
    logic [grwc_pkg::DIVD_W:0] w_diff;
    logic                      w_ge;

    assign w_t    = {r_rem, r_quot[grwc_pkg::DIVN_W-1]};
    assign w_ge   = w_t >= {1'b0, r_dvs};
    assign w_diff = w_t - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[grwc_pkg::DIVD_W-1:0] : w_t[grwc_pkg::DIVD_W-1:0];
                r_quot <= {r_quot[grwc_pkg::DIVN_W-2:0], w_ge};
                if (r_cnt == CNT_W'(grwc_pkg::DIVN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_quot      = r_quot;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// File: rtl/grwc_sqrt.sv
// Bit-pair integer square root, one result bit per cycle.
module grwc_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [grwc_pkg::D2_W-1:0]   i_value,
    output logic [grwc_pkg::ROOT_W-1:0] o_root,
    output grwc_pkg::t_unit_stat        o_stat
);

    localparam int CNT_W = $clog2(grwc_pkg::ROOT_W);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [grwc_pkg::D2_W-1:0] r_v;
    logic [grwc_pkg::D2_W-1:0] r_r;
    logic [grwc_pkg::D2_W-1:0] r_bit;

    logic [grwc_pkg::D2_W-1:0] w_rb;
    logic                      w_ge;

    assign w_rb = r_r + r_bit;
    assign w_ge = r_v >= w_rb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= i_value;
                r_r    <= '0;
                r_bit  <= grwc_pkg::D2_W'(1) << (grwc_pkg::D2_W - 2);
            end else if (r_busy) begin
                if (w_ge) begin
                    r_v <= r_v - w_rb;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_cnt == CNT_W'(grwc_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_root      = r_r[grwc_pkg::ROOT_W-1:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// File: rtl/grid_ray_wall_caster_unit.sv
// Top level: wall map, ray probe sequencer and result register.
//
// Input stream: tuser selects the request kind. A map write stores one cell
// bit in the same cycle it is taken and yields no result. A cast request
// runs both grid probes and yields exactly one result on the output stream.
// Output stream: tdata carries hit point, distance and wall slice, tuser the
// line kind and the wall flag.
// The serial divider dominates the time of a cast: up to five quotients
// (offset and slope for each probe that runs, and the slice height), then
// the square root, two trig runs, and a read and a check state for each map
// cell visited by each probe.
// tready is high only while the sequencer is idle; map writes then go at
// one per cycle.
// The result sits in an output register; a new request may be taken while
// it waits, and the next result holds in the final state until the
// receiver has taken the previous one.
// Reset is synchronous; it empties the map at once (per-cell valid bits)
// and drops any pending result.
module grid_ray_wall_caster_unit #(
    parameter int GRID_SIDE     = grwc_pkg::GRID_SIDE_DEF,
    parameter int MAX_STEPS     = grwc_pkg::MAX_STEPS_DEF,
    parameter int SCREEN_HEIGHT = grwc_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // cell_index[7:0] cell_wall[8] pos_x[24:9] pos_y[40:25]
    // ray_angle[56:41] view_angle[72:57], zero fill above
    input  logic [grwc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // opcode[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // hit_x[17:0] hit_y[35:18] distance[53:36] line_height[62:54]
    // line_offset[71:63]
    output logic [grwc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // hit_side[0] wall_found[1]
    output logic [grwc_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int MAP_DEPTH = (CELLS < 256) ? CELLS : 256;
    localparam int AW        = $clog2(MAP_DEPTH);
    localparam int CELL_W    = $clog2(CELLS);
    localparam int MX_W      = $clog2(GRID_SIDE);
    localparam int GX_W      = grwc_pkg::COORD_W - grwc_pkg::CELL_SHIFT;
    localparam int N_W       = $clog2(MAX_STEPS + 1);
    localparam int LH_W      = $clog2(SCREEN_HEIGHT);
    localparam logic [grwc_pkg::DIVN_W-1:0] LH_NUM =
        grwc_pkg::DIVN_W'(SCREEN_HEIGHT) << 26;

    typedef enum logic [3:0] {
        S_IDLE, S_CORD_RAY, S_PSETUP, S_DIV_OFF, S_DIV_STEP, S_RD, S_CHK,
        S_SQ1, S_SQ2, S_PICK, S_SQRT, S_CORD_VIEW, S_LH_MUL, S_LH_DIV, S_DONE
    } t_state;

    t_state r_state;

    // request fields
    logic [7:0]                 w_cell_index;
    logic                       w_cell_wall;
    logic [grwc_pkg::ANG_W-1:0] w_in_ray;

    assign w_cell_index = s_axis_tdata[7:0];
    assign w_cell_wall  = s_axis_tdata[8];
    assign w_in_ray     = s_axis_tdata[56:41];

    // cast context
    grwc_pkg::t_coord           r_px;
    grwc_pkg::t_coord           r_py;
    logic [grwc_pkg::ANG_W-1:0] r_ra;
    logic [grwc_pkg::ANG_W-1:0] r_va;
    grwc_pkg::t_trig            r_c;
    grwc_pkg::t_trig            r_s;

    // probe walk
    logic                              r_vert;
    grwc_pkg::t_coord                  r_pp;
    grwc_pkg::t_coord                  r_qq;
    grwc_pkg::t_coord                  r_qstep;
    logic                              r_pneg;
    logic [N_W-1:0]                    r_n;
    logic                              r_found;
    logic                              r_rd_ok;
    logic signed [grwc_pkg::D2_W-1:0]  r_sq;

    // probe results
    grwc_pkg::t_coord          r_hx;
    grwc_pkg::t_coord          r_hy;
    logic [grwc_pkg::D2_W-1:0] r_hd2;
    logic                      r_hf;
    grwc_pkg::t_coord          r_vx;
    grwc_pkg::t_coord          r_vy;
    logic [grwc_pkg::D2_W-1:0] r_vd2;
    logic                      r_vf;

    logic                          r_side;
    logic [grwc_pkg::ROOT_W-1:0]   r_dist;
    logic [grwc_pkg::DIVD_W-1:0]   r_prod;
    logic [LH_W-1:0]               r_lh;

    logic [MAP_DEPTH-1:0] r_valid;

    logic                               r_out_valid;
    logic [grwc_pkg::OUT_DATA_W-1:0]    r_out_data;
    logic [grwc_pkg::OUT_USER_W-1:0]    r_out_user;

    // arithmetic units and map RAM; trig and divider are shared across steps
    logic                        w_cord_start;
    logic [grwc_pkg::ANG_W-1:0]  w_cord_ang;
    grwc_pkg::t_trig             w_cos;
    grwc_pkg::t_trig             w_sin;
    grwc_pkg::t_unit_stat        w_cord_stat;

    logic                        w_div_start;
    logic [grwc_pkg::DIVN_W-1:0] w_div_num;
    logic [grwc_pkg::DIVD_W-1:0] w_div_den;
    logic [grwc_pkg::DIVN_W-1:0] w_quot;
    grwc_pkg::t_unit_stat        w_div_stat;

    logic                        w_sqrt_start;
    logic [grwc_pkg::D2_W-1:0]   w_sqrt_in;
    logic [grwc_pkg::ROOT_W-1:0] w_root;
    grwc_pkg::t_unit_stat        w_sqrt_stat;

    logic                        w_ram_we;
    logic [AW-1:0]               w_ram_raddr;
    logic [0:0]                  w_ram_rdata;

    logic w_in_acc;
    logic w_out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // probe setup arithmetic
    grwc_pkg::t_coord          w_p0;
    grwc_pkg::t_coord          w_q0;
    grwc_pkg::t_trig           w_pc;
    grwc_pkg::t_trig           w_qc;
    logic                      w_pc_pos;
    logic                      w_qneg;
    logic [grwc_pkg::CELL_SHIFT:0] w_pmag;
    logic [grwc_pkg::TRIG_W-1:0]   w_pcmag;
    logic [grwc_pkg::TRIG_W-1:0]   w_qcmag;
    logic [30:0]               w_off_prod;
    grwc_pkg::t_coord          w_base;
    logic [grwc_pkg::LIM_W-1:0] w_qlim;
    grwc_pkg::t_coord          w_qoff;
    logic                      w_skip;

    assign w_p0     = r_vert ? r_px : r_py;
    assign w_q0     = r_vert ? r_py : r_px;
    assign w_pc     = r_vert ? r_c : r_s;
    assign w_qc     = r_vert ? r_s : r_c;
    assign w_pc_pos = !w_pc[grwc_pkg::TRIG_W-1];
    assign w_qneg   = w_qc[grwc_pkg::TRIG_W-1];
    assign w_pcmag  = w_pc_pos ? w_pc : -w_pc;
    assign w_qcmag  = w_qneg ? -w_qc : w_qc;
    assign w_base   = {w_p0[grwc_pkg::COORD_W-1:grwc_pkg::CELL_SHIFT],
                       grwc_pkg::CELL_SHIFT'(0)};
    assign w_pmag   = w_pc_pos
        ? (grwc_pkg::CELL_SHIFT+1)'(grwc_pkg::CELL_Q)
          - {1'b0, w_p0[grwc_pkg::CELL_SHIFT-1:0]}
        : {1'b0, w_p0[grwc_pkg::CELL_SHIFT-1:0]} + 1'b1;
    assign w_off_prod = 31'(w_pmag) * 31'(w_qcmag);

    // clamp the quotient magnitude, then apply the sign of the minor component
    assign w_qlim = (w_quot > grwc_pkg::DIVN_W'(grwc_pkg::STEP_LIM))
                  ? grwc_pkg::LIM_W'(grwc_pkg::STEP_LIM)
                  : w_quot[grwc_pkg::LIM_W-1:0];
    assign w_qoff = w_qneg ? -grwc_pkg::COORD_W'(w_qlim) : grwc_pkg::COORD_W'(w_qlim);

    assign w_skip = r_vert
        ? (r_ra == 16'd16384 || r_ra == 16'd49152 || w_pc == '0)
        : (r_ra == 16'd0 || r_ra == 16'd32768 || w_pc == '0);

    // map lookup address
    grwc_pkg::t_coord  w_x;
    grwc_pkg::t_coord  w_y;
    logic              w_inmap;
    logic [MX_W-1:0]   w_mx;
    logic [MX_W-1:0]   w_my;
    logic [CELL_W-1:0] w_idx;
    logic              w_inrange;

    assign w_x = r_vert ? r_pp : r_qq;
    assign w_y = r_vert ? r_qq : r_pp;
    assign w_inmap = !w_x[grwc_pkg::COORD_W-1] && !w_y[grwc_pkg::COORD_W-1]
        && (w_x[grwc_pkg::COORD_W-1:grwc_pkg::CELL_SHIFT] < GX_W'(GRID_SIDE))
        && (w_y[grwc_pkg::COORD_W-1:grwc_pkg::CELL_SHIFT] < GX_W'(GRID_SIDE));
    assign w_mx = w_x[grwc_pkg::CELL_SHIFT +: MX_W];
    assign w_my = w_y[grwc_pkg::CELL_SHIFT +: MX_W];
    assign w_idx = CELL_W'(w_my) * CELL_W'(GRID_SIDE) + CELL_W'(w_mx);
    assign w_inrange = (CELL_W+1)'(w_idx) < (CELL_W+1)'(MAP_DEPTH);
    assign w_ram_raddr = w_idx[AW-1:0];

    // distance terms
    grwc_pkg::t_coord                 w_dx;
    grwc_pkg::t_coord                 w_dy;
    grwc_pkg::t_coord                 w_mop;
    logic signed [grwc_pkg::D2_W-1:0] w_msq;

    assign w_dx  = w_x - r_px;
    assign w_dy  = w_y - r_py;
    assign w_mop = (r_state == S_SQ1) ? w_dx : w_dy;
    assign w_msq = w_mop * w_mop;

    logic w_side;
    assign w_side    = r_vd2 < r_hd2;
    assign w_sqrt_in = w_side ? r_vd2 : r_hd2;

    // unit controls
    assign w_cord_start = (w_in_acc && s_axis_tuser == grwc_pkg::OP_CAST)
                       || (r_state == S_SQRT && w_sqrt_stat.done);
    assign w_cord_ang   = (r_state == S_IDLE) ? w_in_ray : r_va - r_ra;

    assign w_div_start = (r_state == S_PSETUP && !w_skip)
                      || (r_state == S_DIV_OFF && w_div_stat.done)
                      || (r_state == S_LH_MUL);
    always_comb begin
        case (r_state)
            S_PSETUP: begin
                w_div_num = grwc_pkg::DIVN_W'(w_off_prod);
                w_div_den = grwc_pkg::DIVD_W'(w_pcmag);
            end
            S_DIV_OFF: begin
                w_div_num = grwc_pkg::DIVN_W'(w_qcmag) << grwc_pkg::CELL_SHIFT;
                w_div_den = grwc_pkg::DIVD_W'(w_pcmag);
            end
            default: begin
                w_div_num = LH_NUM;
                w_div_den = r_prod;
            end
        endcase
    end

    assign w_sqrt_start = (r_state == S_PICK);

    assign w_ram_we = w_in_acc && s_axis_tuser == grwc_pkg::OP_WRITE
                   && ({1'b0, w_cell_index} < 9'(MAP_DEPTH));

    // result packing
    grwc_pkg::t_coord  w_cx;
    grwc_pkg::t_coord  w_cy;
    logic [17:0]       w_ox;
    logic [17:0]       w_oy;
    logic [17:0]       w_od;
    logic [11:0]       w_lh12;
    logic [11:0]       w_lo12;

    assign w_cx = r_side ? r_vx : r_hx;
    assign w_cy = r_side ? r_vy : r_hy;
    assign w_ox = (w_cx > 32'sd131071) ? 18'h1FFFF
                : (w_cx < -32'sd131072) ? 18'h20000 : w_cx[17:0];
    assign w_oy = (w_cy > 32'sd131071) ? 18'h1FFFF
                : (w_cy < -32'sd131072) ? 18'h20000 : w_cy[17:0];
    assign w_od = (r_dist > 32'd262143) ? 18'h3FFFF : r_dist[17:0];
    assign w_lh12 = 12'(r_lh);
    assign w_lo12 = 12'(SCREEN_HEIGHT / 2) - (w_lh12 >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_ram_we) begin
                        r_valid[w_cell_index[AW-1:0]] <= 1'b1;
                    end
                    if (w_in_acc && s_axis_tuser == grwc_pkg::OP_CAST) begin
                        r_px    <= grwc_pkg::COORD_W'(s_axis_tdata[24:9]);
                        r_py    <= grwc_pkg::COORD_W'(s_axis_tdata[40:25]);
                        r_ra    <= w_in_ray;
                        r_va    <= s_axis_tdata[72:57];
                        r_state <= S_CORD_RAY;
                    end
                end
                S_CORD_RAY: begin
                    if (w_cord_stat.done) begin
                        r_c     <= w_cos;
                        r_s     <= w_sin;
                        r_vert  <= 1'b0;
                        r_state <= S_PSETUP;
                    end
                end
                S_PSETUP: begin
                    if (w_skip) begin
                        // skipped probe: stays at the player, never nearer
                        if (r_vert) begin
                            r_vx    <= r_px;
                            r_vy    <= r_py;
                            r_vd2   <= '1;
                            r_vf    <= 1'b0;
                            r_state <= S_PICK;
                        end else begin
                            r_hx    <= r_px;
                            r_hy    <= r_py;
                            r_hd2   <= '1;
                            r_hf    <= 1'b0;
                            r_vert  <= 1'b1;
                        end
                    end else begin
                        r_pneg  <= !w_pc_pos;
                        r_pp    <= w_pc_pos ? w_base + grwc_pkg::CELL_Q : w_base - 1;
                        r_state <= S_DIV_OFF;
                    end
                end
                S_DIV_OFF: begin
                    if (w_div_stat.done) begin
                        r_qq    <= w_q0 + w_qoff;
                        r_state <= S_DIV_STEP;
                    end
                end
                S_DIV_STEP: begin
                    if (w_div_stat.done) begin
                        r_qstep <= w_qoff;
                        r_n     <= '0;
                        r_found <= 1'b0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_rd_ok <= w_inmap && w_inrange && r_valid[w_ram_raddr];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_rd_ok && w_ram_rdata[0]) begin
                        r_found <= 1'b1;
                        r_state <= S_SQ1;
                    end else begin
                        // advance to the next grid line
                        r_pp <= r_pneg ? r_pp - grwc_pkg::CELL_Q : r_pp + grwc_pkg::CELL_Q;
                        r_qq <= r_qq + r_qstep;
                        r_n  <= r_n + 1'b1;
                        if (r_n == N_W'(MAX_STEPS - 1)) begin
                            r_state <= S_SQ1;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_SQ1: begin
                    r_sq    <= w_msq;
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    if (r_vert) begin
                        r_vx    <= w_x;
                        r_vy    <= w_y;
                        r_vd2   <= r_sq + w_msq;
                        r_vf    <= r_found;
                        r_state <= S_PICK;
                    end else begin
                        r_hx    <= w_x;
                        r_hy    <= w_y;
                        r_hd2   <= r_sq + w_msq;
                        r_hf    <= r_found;
                        r_vert  <= 1'b1;
                        r_state <= S_PSETUP;
                    end
                end
                S_PICK: begin
                    r_side  <= w_side;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (w_sqrt_stat.done) begin
                        r_dist  <= w_root;
                        r_state <= S_CORD_VIEW;
                    end
                end
                S_CORD_VIEW: begin
                    if (w_cord_stat.done) begin
                        r_prod <= grwc_pkg::DIVD_W'(r_dist)
                                * grwc_pkg::DIVD_W'(w_cos[15:0]);
                        if (w_cos[grwc_pkg::TRIG_W-1]) begin
                            r_lh    <= '0;
                            r_state <= S_DONE;
                        end else if (r_dist == '0 || w_cos == '0) begin
                            r_lh    <= LH_W'(SCREEN_HEIGHT - 1);
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_LH_MUL;
                        end
                    end
                end
                S_LH_MUL: begin
                    r_state <= S_LH_DIV;
                end
                S_LH_DIV: begin
                    if (w_div_stat.done) begin
                        r_lh <= (w_quot >= grwc_pkg::DIVN_W'(SCREEN_HEIGHT))
                              ? LH_W'(SCREEN_HEIGHT - 1) : w_quot[LH_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the previous result has been taken
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {w_lo12[8:0], w_lh12[8:0], w_od, w_oy, w_ox};
                        r_out_user  <= {r_side ? r_vf : r_hf, r_side};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    grwc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cord_start),
        .i_angle (w_cord_ang),
        .o_cos   (w_cos),
        .o_sin   (w_sin),
        .o_stat  (w_cord_stat)
    );

    grwc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_quot     (w_quot),
        .o_stat     (w_div_stat)
    );

    grwc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value (w_sqrt_in),
        .o_root  (w_root),
        .o_stat  (w_sqrt_stat)
    );

    grwc_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_cell_index[AW-1:0]),
        .i_wdata (w_cell_wall),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider restarted while busy");

    a_cord_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cord_start |-> !w_cord_stat.busy)
        else $error("trig unit restarted while busy");

    a_idle_units_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_div_stat.busy && !w_sqrt_stat.busy && !w_cord_stat.busy)
        else $error("request taken while a unit is still running");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (r_n < N_W'(MAX_STEPS)))
        else $error("probe walked past the step limit");

    a_lh_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (32'(r_lh) < SCREEN_HEIGHT))
        else $error("slice height above clamp");

endmodule
